@@ rtl/apio_pkg.sv @@
// ATA PIO request sequencer: shared types, codes and task-file constants.
// No dependencies; imported by every module under rtl.
package apio_pkg;

	localparam int QUEUE_DEPTH_DEF   = 16;
	localparam int DWORDS_PER_SECTOR = 128;
	localparam int JOBQ_DEPTH        = 4;

	// request item
	typedef struct packed {
		logic        cmd;
		logic [23:0] block_number;
		logic        drive;
		logic        write_request;
		logic [7:0]  request_tag;
		logic [7:0]  status;
	} req_t;

	// result item
	typedef struct packed {
		logic [2:0] kind;
		logic [9:0] port;
		logic [9:0] value;
		logic [7:0] done_tag;
		logic       error;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [24:0] block_limit;
		logic [2:0]  sectors_per_block;
		logic        second_disk_present;
	} cfg_t;

	typedef struct packed {
		logic [23:0] block;
		logic        drive;
		logic        write;
		logic [7:0]  tag;
	} entry_t;

	typedef enum logic [1:0] {
		JOB_REJECT,
		JOB_ISSUE,
		JOB_RETIRE
	} job_kind_t;

	typedef struct packed {
		job_kind_t  kind;
		entry_t     entry;
		logic [1:0] reason;
		logic       err;
		logic       last;
	} job_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_RETIRE,
		F_NEXT
	} front_state_t;

	localparam logic CMD_SUBMIT = 1'b0;
	localparam logic CMD_IRQ    = 1'b1;

	localparam logic [2:0] KIND_REGW   = 3'd0;
	localparam logic [2:0] KIND_DOUT   = 3'd1;
	localparam logic [2:0] KIND_DIN    = 3'd2;
	localparam logic [2:0] KIND_DONE   = 3'd3;
	localparam logic [2:0] KIND_REJECT = 3'd4;

	localparam logic [1:0] RSN_BLOCK = 2'd0;
	localparam logic [1:0] RSN_DRIVE = 2'd1;
	localparam logic [1:0] RSN_FULL  = 2'd2;

	localparam logic [1:0] REG_SPB   = 2'd0;
	localparam logic [1:0] REG_LIMIT = 2'd1;
	localparam logic [1:0] REG_DISK1 = 2'd2;

	localparam logic [9:0] PORT_DATA   = 10'h1f0;
	localparam logic [9:0] PORT_COUNT  = 10'h1f2;
	localparam logic [9:0] PORT_LBA0   = 10'h1f3;
	localparam logic [9:0] PORT_LBA1   = 10'h1f4;
	localparam logic [9:0] PORT_LBA2   = 10'h1f5;
	localparam logic [9:0] PORT_DEVHD  = 10'h1f6;
	localparam logic [9:0] PORT_CMD    = 10'h1f7;
	localparam logic [9:0] PORT_CTRL   = 10'h3f6;

	localparam logic [7:0] DEVHD_BASE  = 8'he0;
	localparam logic [7:0] ATA_RD      = 8'h20;
	localparam logic [7:0] ATA_WR      = 8'h30;
	localparam logic [7:0] ATA_RD_MUL  = 8'hc4;
	localparam logic [7:0] ATA_WR_MUL  = 8'hc5;
	localparam logic [7:0] ST_FAULT    = 8'h20;
	localparam logic [7:0] ST_ERR      = 8'h01;

	localparam logic [24:0] LIMIT_RST  = 25'd1000;
	localparam logic [2:0]  SPB_RST    = 3'd1;

endpackage

@@ rtl/apio_regs.sv @@
// Configuration registers behind an APB-style port.
// Depends on apio_pkg (cfg_t, register indexes, reset values).
module apio_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output apio_pkg::cfg_t      cfg
);
	import apio_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] idx;

	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sectors_per_block   <= SPB_RST;
			cfg_q.block_limit         <= LIMIT_RST;
			cfg_q.second_disk_present <= 1'b0;
		end else if (wr_en) begin
			unique case (idx)
				REG_SPB:   cfg_q.sectors_per_block   <= pwdata[2:0];
				REG_LIMIT: cfg_q.block_limit         <= pwdata[24:0];
				REG_DISK1: cfg_q.second_disk_present <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_SPB:   prdata = {29'd0, cfg_q.sectors_per_block};
			REG_LIMIT: prdata = {7'd0, cfg_q.block_limit};
			REG_DISK1: prdata = {31'd0, cfg_q.second_disk_present};
			default:   prdata = '0;
		endcase
	end

endmodule

@@ rtl/apio_front.sv @@
// Front end: accepts requests, checks submits, owns the request FIFO memory,
// and posts reject/issue/retire jobs. Depends on apio_pkg.
module apio_front #(
	parameter int QUEUE_DEPTH = apio_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  apio_pkg::cfg_t cfg,
	input  logic           req_valid,
	output logic           req_ready,
	input  apio_pkg::req_t req,
	input  logic           jq_room,
	output logic           job_push,
	output apio_pkg::job_t job
);
	import apio_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t             mem [QUEUE_DEPTH];
	entry_t             rd_q;
	logic [PTR_W-1:0]   head_q, tail_q;
	logic [CNT_W-1:0]   count_q;
	logic               err_q;
	front_state_t       state_q, state_d;

	entry_t             in_entry;
	logic               accept, is_submit, bad_block, bad_drive, full;
	logic               enq, deq;

	function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign in_entry  = '{block: req.block_number, drive: req.drive,
	                     write: req.write_request, tag: req.request_tag};
	assign accept    = req_valid && req_ready;
	assign is_submit = (req.cmd == CMD_SUBMIT);
	assign bad_block = {1'b0, req.block_number} >= cfg.block_limit;
	assign bad_drive = req.drive && !cfg.second_disk_present;
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign enq       = accept && is_submit && !bad_block && !bad_drive && !full;
	assign deq       = accept && !is_submit && (count_q != '0);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			F_IDLE:   if (deq) state_d = F_RETIRE;
			F_RETIRE: state_d = (count_q != '0) ? F_NEXT : F_IDLE;
			F_NEXT:   state_d = F_IDLE;
			default:  state_d = F_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		job_push  = 1'b0;
		job       = '{kind: JOB_REJECT, entry: in_entry, reason: RSN_BLOCK,
		              err: 1'b0, last: 1'b1};
		unique case (state_q)
			F_IDLE: begin
				req_ready = jq_room;
				if (req_valid && jq_room && is_submit) begin
					priority if (bad_block) begin
						job_push   = 1'b1;
						job.reason = RSN_BLOCK;
					end else if (bad_drive) begin
						job_push   = 1'b1;
						job.reason = RSN_DRIVE;
					end else if (full) begin
						job_push   = 1'b1;
						job.reason = RSN_FULL;
					end else if (count_q == '0) begin
						job_push = 1'b1;
						job.kind = JOB_ISSUE;
					end else begin
						job_push = 1'b0;
					end
				end
			end
			F_RETIRE: begin
				job_push  = 1'b1;
				job.kind  = JOB_RETIRE;
				job.entry = rd_q;
				job.err   = err_q && !rd_q.write;
				job.last  = (count_q == '0);
			end
			F_NEXT: begin
				job_push  = 1'b1;
				job.kind  = JOB_ISSUE;
				job.entry = rd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (enq) begin
				tail_q  <= wrap_next(tail_q);
				count_q <= count_q + 1'b1;
			end
			if (deq) begin
				head_q  <= wrap_next(head_q);
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			err_q <= (req.status & (ST_FAULT | ST_ERR)) != 8'd0;
	end

	// request FIFO storage, registered read at the head
	always_ff @(posedge clk) begin
		if (enq)
			mem[tail_q] <= in_entry;
		rd_q <= mem[head_q];
	end

endmodule

@@ rtl/apio_jobq.sv @@
// Short job queue between front and back ends.
// Depends on apio_pkg (job_t, JOBQ_DEPTH).
module apio_jobq (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  apio_pkg::job_t push_job,
	output logic           room,
	input  logic           pop,
	output logic           head_valid,
	output apio_pkg::job_t head_job
);
	import apio_pkg::*;

	localparam int PTR_W = $clog2(JOBQ_DEPTH);
	localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);

	job_t             slot_q [JOBQ_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_pop;

	// room for the two jobs an interrupt can post
	assign room       = (cnt_q <= CNT_W'(JOBQ_DEPTH - 2));
	assign head_valid = (cnt_q != '0);
	assign head_job   = slot_q[rd_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			unique case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_job;
	end

endmodule

@@ rtl/apio_back.sv @@
// Back end: steps each job through its task-file writes, bursts, completion or
// reject, one result per cycle while out_q is free or read. Depends on apio_pkg.
module apio_back (
	input  logic           clk,
	input  logic           arst_n,
	input  apio_pkg::cfg_t cfg,
	input  logic           job_valid,
	input  apio_pkg::job_t job,
	output logic           job_pop,
	output logic           res_valid,
	input  logic           res_ready,
	output apio_pkg::res_t res
);
	import apio_pkg::*;

	logic [2:0]  step_q;
	logic        out_valid_q;
	res_t        out_q;
	res_t        r;
	logic        job_end, fire;
	logic [27:0] sector;
	logic [9:0]  burst;
	logic [7:0]  ata_cmd;
	logic        single;

	assign sector  = 28'(job.entry.block) * 28'(cfg.sectors_per_block);
	assign burst   = 10'(cfg.sectors_per_block * DWORDS_PER_SECTOR);
	assign single  = (cfg.sectors_per_block == 3'd1);
	assign ata_cmd = job.entry.write ? (single ? ATA_WR : ATA_WR_MUL)
	                                 : (single ? ATA_RD : ATA_RD_MUL);

	assign fire      = job_valid && (!out_valid_q || res_ready);
	assign job_pop   = fire && job_end;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_comb begin
		r = '{kind: KIND_REGW, port: 10'd0, value: 10'd0,
		      done_tag: job.entry.tag, error: 1'b0, last: 1'b0};
		job_end = 1'b0;
		unique case (job.kind)
			JOB_REJECT: begin
				r.kind  = KIND_REJECT;
				r.value = {8'd0, job.reason};
				job_end = 1'b1;
			end
			JOB_ISSUE: begin
				unique case (step_q)
					3'd0: r.port = PORT_CTRL;
					3'd1: begin
						r.port  = PORT_COUNT;
						r.value = {7'd0, cfg.sectors_per_block};
					end
					3'd2: begin
						r.port  = PORT_LBA0;
						r.value = {2'd0, sector[7:0]};
					end
					3'd3: begin
						r.port  = PORT_LBA1;
						r.value = {2'd0, sector[15:8]};
					end
					3'd4: begin
						r.port  = PORT_LBA2;
						r.value = {2'd0, sector[23:16]};
					end
					3'd5: begin
						r.port  = PORT_DEVHD;
						r.value = {2'd0, DEVHD_BASE | {3'd0, job.entry.drive, sector[27:24]}};
					end
					3'd6: begin
						r.port  = PORT_CMD;
						r.value = {2'd0, ata_cmd};
						job_end = !job.entry.write;
					end
					default: begin
						r.kind  = KIND_DOUT;
						r.port  = PORT_DATA;
						r.value = burst;
						job_end = 1'b1;
					end
				endcase
			end
			JOB_RETIRE: begin
				if (step_q == 3'd0 && !job.entry.write && !job.err) begin
					r.kind  = KIND_DIN;
					r.port  = PORT_DATA;
					r.value = burst;
				end else begin
					r.kind  = KIND_DONE;
					r.error = job.err;
					job_end = 1'b1;
				end
			end
			default: job_end = 1'b1;
		endcase
		r.last = job_end && job.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
			step_q      <= job_end ? 3'd0 : step_q + 3'd1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			out_q <= r;
	end

endmodule

@@ rtl/ata_pio_request_sequencer_unit.sv @@
// ATA PIO request sequencer, top level: config registers, front end, job queue, back end.
// Depends on apio_pkg, apio_regs, apio_front, apio_jobq, apio_back.
// Throughput: one result per cycle from the back-end step counter unless res_ready
// holds the output. Submits are taken back to back and an interrupt that retires a
// request blocks others until its jobs are posted, all while the job queue has room.
// Reset clears pointers, counts and queues and loads the register defaults; request
// FIFO memory contents stay undefined and need no clearing pass.
module ata_pio_request_sequencer_unit #(
	parameter int QUEUE_DEPTH = apio_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [3:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready,
	input  logic           req_valid,
	output logic           req_ready,
	input  apio_pkg::req_t req,
	output logic           res_valid,
	input  logic           res_ready,
	output apio_pkg::res_t res
);
	import apio_pkg::*;

	cfg_t cfg;
	job_t push_job, head_job;
	logic job_push, jq_room, job_pop, head_valid;

	apio_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	apio_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.jq_room   (jq_room),
		.job_push  (job_push),
		.job       (push_job)
	);

	apio_jobq u_jobq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_push),
		.push_job   (push_job),
		.room       (jq_room),
		.pop        (job_pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	apio_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.job_valid (head_valid),
		.job       (head_job),
		.job_pop   (job_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

endmodule

@@ tb/ata_pio_request_sequencer_unit_tb.sv @@
// Self-checking bench for the ATA PIO request sequencer: directed and random requests,
// APB register settings, a request-level predictor and an in-order result scoreboard.
// Depends on apio_pkg and the ata_pio_request_sequencer_unit RTL.
module ata_pio_request_sequencer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import apio_pkg::*;

	localparam int FIFO_DEPTH   = QUEUE_DEPTH_DEF;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 10;
	localparam int PHASE_ITEMS  = 26;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        req_valid = 1'b0;
	logic        req_ready;
	req_t        req = '0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	res_t        res;

	// predictor state
	entry_t      disk_fifo[$];
	res_t        due_results[$];
	res_t        step_out[$];
	logic [2:0]  cur_spb = SPB_RST;
	logic [24:0] cur_limit = LIMIT_RST;
	logic        cur_disk1 = 1'b0;

	// stimulus state
	req_t        req_backlog[$];
	int          gen_depth = 0;
	logic        req_fire = 1'b0;
	int          tx_gap = 0;
	int          rx_gap = 0;
	logic        tx_idle_on = 1'b1;
	logic        rx_idle_on = 1'b1;
	int          hold_asks = 0;
	int          hold_seen = 0;
	int          hold_left = 0;

	int          cycle_cnt = 0;
	int          mismatches = 0;
	int          reqs_taken = 0;
	int          results_seen = 0;
	int          rejects_seen = 0;
	int          fulls_seen = 0;
	int          completions_seen = 0;
	int          reg_writes = 0;

	ata_pio_request_sequencer_unit #(.QUEUE_DEPTH(FIFO_DEPTH)) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic res_t result_of(logic [2:0] k, logic [9:0] p, logic [9:0] v,
			logic [7:0] t, logic e);
		res_t r;
		r.kind = k;
		r.port = p;
		r.value = v;
		r.done_tag = t;
		r.error = e;
		r.last = 1'b0;
		return r;
	endfunction

	function automatic void add_taskfile(entry_t e);
		logic [31:0] sector;
		logic [7:0]  opcode;
		logic [7:0]  devhd;
		sector = 32'(e.block) * 32'(cur_spb);
		if (e.write)
			opcode = (cur_spb == 3'd1) ? ATA_WR : ATA_WR_MUL;
		else
			opcode = (cur_spb == 3'd1) ? ATA_RD : ATA_RD_MUL;
		devhd = DEVHD_BASE | {3'b000, e.drive, sector[27:24]};
		step_out.push_back(result_of(KIND_REGW, PORT_CTRL, 10'd0, e.tag, 1'b0));
		step_out.push_back(result_of(KIND_REGW, PORT_COUNT, {7'b0, cur_spb}, e.tag, 1'b0));
		step_out.push_back(result_of(KIND_REGW, PORT_LBA0, {2'b0, sector[7:0]}, e.tag, 1'b0));
		step_out.push_back(result_of(KIND_REGW, PORT_LBA1, {2'b0, sector[15:8]}, e.tag, 1'b0));
		step_out.push_back(result_of(KIND_REGW, PORT_LBA2, {2'b0, sector[23:16]}, e.tag, 1'b0));
		step_out.push_back(result_of(KIND_REGW, PORT_DEVHD, {2'b0, devhd}, e.tag, 1'b0));
		step_out.push_back(result_of(KIND_REGW, PORT_CMD, {2'b0, opcode}, e.tag, 1'b0));
		if (e.write)
			step_out.push_back(result_of(KIND_DOUT, PORT_DATA, {cur_spb, 7'b0}, e.tag, 1'b0));
	endfunction

	function automatic void model_request(req_t r);
		entry_t e;
		entry_t head;
		logic   err;
		res_t   o;
		step_out.delete();
		e.block = r.block_number;
		e.drive = r.drive;
		e.write = r.write_request;
		e.tag = r.request_tag;
		if (r.cmd == CMD_SUBMIT) begin
			if ({1'b0, e.block} >= cur_limit)
				step_out.push_back(result_of(KIND_REJECT, 10'd0, {8'b0, RSN_BLOCK}, e.tag, 1'b0));
			else if (e.drive && !cur_disk1)
				step_out.push_back(result_of(KIND_REJECT, 10'd0, {8'b0, RSN_DRIVE}, e.tag, 1'b0));
			else if (disk_fifo.size() >= FIFO_DEPTH)
				step_out.push_back(result_of(KIND_REJECT, 10'd0, {8'b0, RSN_FULL}, e.tag, 1'b0));
			else begin
				disk_fifo.push_back(e);
				if (disk_fifo.size() == 1)
					add_taskfile(e);
			end
		end else if (disk_fifo.size() != 0) begin
			head = disk_fifo.pop_front();
			err = 1'b0;
			if (!head.write) begin
				err = |(r.status & (ST_FAULT | ST_ERR));
				if (!err)
					step_out.push_back(result_of(KIND_DIN, PORT_DATA, {cur_spb, 7'b0},
						head.tag, 1'b0));
			end
			step_out.push_back(result_of(KIND_DONE, 10'd0, 10'd0, head.tag, err));
			if (disk_fifo.size() != 0)
				add_taskfile(disk_fifo[0]);
		end
		for (int i = 0; i < step_out.size(); i++) begin
			o = step_out[i];
			o.last = (i == step_out.size() - 1);
			due_results.push_back(o);
		end
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			mismatches++;
			$display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
		end
	endfunction

	function automatic void check_result(res_t got);
		res_t want;
		results_seen++;
		if (got.kind == KIND_REJECT) begin
			rejects_seen++;
			if (got.value == {8'b0, RSN_FULL})
				fulls_seen++;
		end
		if (got.kind == KIND_DONE)
			completions_seen++;
		if (due_results.size() == 0) begin
			mismatches++;
			$display("%0t: unexpected result kind %0d port 0x%0h value 0x%0h tag 0x%0h",
				$time, got.kind, got.port, got.value, got.done_tag);
		end else begin
			want = due_results.pop_front();
			check_field("kind", 32'(want.kind), 32'(got.kind));
			check_field("port", 32'(want.port), 32'(got.port));
			check_field("value", 32'(want.value), 32'(got.value));
			check_field("done_tag", 32'(want.done_tag), 32'(got.done_tag));
			check_field("error", 32'(want.error), 32'(got.error));
			check_field("last", 32'(want.last), 32'(got.last));
		end
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// monitor, predictor and timeout
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		req_fire <= req_valid && req_ready;
		if (arst_n && req_valid && req_ready) begin
			reqs_taken++;
			model_request(req);
		end
		if (arst_n && res_valid && res_ready)
			check_result(res);
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_cnt, due_results.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// request driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_fire) begin
				if (tx_gap > 0) begin
					req_valid <= 1'b0;
					tx_gap <= tx_gap - 1;
				end else if (req_backlog.size() != 0) begin
					req <= req_backlog.pop_front();
					req_valid <= 1'b1;
					tx_gap <= tx_idle_on ? pick_gap() : 0;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// result receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_seen != hold_asks) begin
				hold_seen <= hold_asks;
				hold_left <= HOLD_CYCLES;
				res_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				res_ready <= 1'b0;
			end else if (rx_gap > 0) begin
				rx_gap <= rx_gap - 1;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
				if (rx_idle_on && $urandom_range(0, 3) == 0)
					rx_gap <= pick_gap();
			end
		end
	end

	task automatic apb_cycle(input logic [1:0] idx, input logic wr, input logic [31:0] data,
			output logic [31:0] rd);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic set_reg(input logic [1:0] idx, input logic [31:0] data);
		logic [31:0] rd;
		logic [31:0] want;
		apb_cycle(idx, 1'b1, data, rd);
		reg_writes++;
		case (idx)
			REG_SPB: cur_spb = data[2:0];
			REG_LIMIT: cur_limit = data[24:0];
			REG_DISK1: cur_disk1 = data[0];
			default: ;
		endcase
		apb_cycle(idx, 1'b0, 32'd0, rd);
		case (idx)
			REG_SPB: want = {29'b0, cur_spb};
			REG_LIMIT: want = {7'b0, cur_limit};
			default: want = {31'b0, cur_disk1};
		endcase
		check_field("register readback", want, rd);
	endtask

	task automatic set_config(input logic [2:0] spb, input logic [24:0] lim, input logic d1);
		set_reg(REG_SPB, {29'b0, spb});
		set_reg(REG_LIMIT, {7'b0, lim});
		set_reg(REG_DISK1, {31'b0, d1});
	endtask

	function automatic req_t submit_item(logic [23:0] blk, logic drv, logic wr, logic [7:0] tag);
		req_t r;
		r.cmd = CMD_SUBMIT;
		r.block_number = blk;
		r.drive = drv;
		r.write_request = wr;
		r.request_tag = tag;
		r.status = 8'($urandom);
		return r;
	endfunction

	function automatic req_t irq_item(logic [7:0] st);
		req_t r;
		r.cmd = CMD_IRQ;
		r.block_number = 24'($urandom);
		r.drive = 1'($urandom_range(0, 1));
		r.write_request = 1'($urandom_range(0, 1));
		r.request_tag = 8'($urandom);
		r.status = st;
		return r;
	endfunction

	function automatic logic [7:0] irq_status();
		if ($urandom_range(0, 2) == 0)
			return 8'($urandom);
		return 8'($urandom) & ~(ST_FAULT | ST_ERR);
	endfunction

	// tracks how deep the request FIFO will be once this request is taken
	task automatic queue_req(input req_t r);
		req_backlog.push_back(r);
		if (r.cmd == CMD_SUBMIT) begin
			if ({1'b0, r.block_number} < cur_limit && (!r.drive || cur_disk1)
					&& gen_depth < FIFO_DEPTH)
				gen_depth++;
		end else if (gen_depth > 0) begin
			gen_depth--;
		end
	endtask

	task automatic drain_fifo();
		while (gen_depth > 0)
			queue_req(irq_item(irq_status()));
	endtask

	task automatic wait_drained();
		while (req_backlog.size() != 0 || req_valid || due_results.size() != 0
				|| hold_left != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_phase(input logic [2:0] spb, input logic [24:0] lim, input logic d1,
			input int n);
		int          pick;
		logic        want_irq;
		logic [23:0] top;
		logic [23:0] blk;
		logic        drv;
		set_config(spb, lim, d1);
		tx_idle_on = ($urandom_range(0, 3) != 0);
		rx_idle_on = ($urandom_range(0, 3) != 0);
		top = (cur_limit > 25'h0FF_FFFF) ? 24'hFF_FFFF : 24'(cur_limit - 25'd1);
		repeat (n) begin
			pick = $urandom_range(0, 99);
			if (gen_depth == 0)
				want_irq = (pick < 10);
			else if (gen_depth >= 12)
				want_irq = (pick < 80);
			else
				want_irq = (pick < 45);
			if (want_irq) begin
				queue_req(irq_item(irq_status()));
			end else begin
				blk = 24'($urandom_range(0, 32'(top)));
				drv = cur_disk1 ? 1'($urandom_range(0, 1)) : 1'b0;
				if ($urandom_range(0, 99) >= 88) begin
					blk = 24'($urandom);
					drv = 1'($urandom_range(0, 1));
				end
				queue_req(submit_item(blk, drv, 1'($urandom_range(0, 1)), 8'($urandom)));
			end
		end
		drain_fifo();
		wait_drained();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: rejection order, queued behind, empty-queue interrupt, status bits
		queue_req(irq_item(8'hff));
		queue_req(submit_item(24'd999, 1'b0, 1'b0, 8'h00));
		queue_req(submit_item(24'd1000, 1'b0, 1'b0, 8'h11));
		queue_req(submit_item(24'hFF_FFFF, 1'b1, 1'b1, 8'haa));
		queue_req(submit_item(24'd5, 1'b1, 1'b0, 8'h22));
		queue_req(submit_item(24'd0, 1'b0, 1'b1, 8'hff));
		queue_req(irq_item(ST_FAULT));
		queue_req(irq_item(8'hff));
		queue_req(submit_item(24'd1, 1'b0, 1'b0, 8'h5a));
		queue_req(irq_item(8'h00));
		queue_req(submit_item(24'd2, 1'b0, 1'b0, 8'ha5));
		queue_req(irq_item(ST_ERR));
		queue_req(irq_item(8'hde));
		wait_drained();

		set_config(3'd7, 25'h100_0000, 1'b1);
		queue_req(submit_item(24'hFF_FFFF, 1'b1, 1'b1, 8'h81));
		queue_req(submit_item(24'hFF_FFFF, 1'b0, 1'b0, 8'h7e));
		queue_req(irq_item(8'hde));
		queue_req(irq_item(8'h00));
		wait_drained();

		// zero sectors per block goes through as is
		set_config(3'd0, 25'd1, 1'b1);
		queue_req(submit_item(24'd0, 1'b1, 1'b0, 8'h01));
		queue_req(submit_item(24'd1, 1'b0, 1'b0, 8'h02));
		queue_req(submit_item(24'd0, 1'b0, 1'b1, 8'h03));
		queue_req(irq_item(ST_FAULT | ST_ERR));
		queue_req(irq_item(8'h00));
		wait_drained();

		random_phase(3'd1, 25'd1000, 1'b0, PHASE_ITEMS);
		random_phase(3'd2, 25'h100_0000, 1'b1, PHASE_ITEMS);

		// results held off while requests keep coming: FIFO fills, full rejects back up
		set_config(3'd3, 25'h100_0000, 1'b1);
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b1;
		hold_asks++;
		repeat (24)
			queue_req(submit_item(24'($urandom), 1'($urandom_range(0, 1)),
				1'($urandom_range(0, 1)), 8'($urandom)));
		drain_fifo();
		wait_drained();

		random_phase(3'd7, 25'd1, 1'b1, PHASE_ITEMS);
		random_phase(3'd4, 25'h0FF_FFFF, 1'b0, PHASE_ITEMS);
		random_phase(3'd0, 25'd300, 1'b1, PHASE_ITEMS);
		random_phase(3'($urandom_range(0, 7)), 25'($urandom_range(1, 32'h100_0000)),
			1'($urandom_range(0, 1)), PHASE_ITEMS);
		random_phase(3'd5, 25'h100_0000, 1'b1, PHASE_ITEMS);

		$display("%0d requests taken, %0d results checked: %0d completions, %0d rejects",
			reqs_taken, results_seen, completions_seen, rejects_seen);
		$display("%0d rejects on a full queue, %0d register writes",
			fulls_seen, reg_writes);
		if (due_results.size() != 0)
			$display("%0d expected results never arrived", due_results.size());
		if (mismatches == 0 && due_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
